FILE: src/rgb2hsv_pkg.sv
// Shared types and constants for the RGB to HSV converter.
// Used by src/rgb_to_hsv_converter.sv; depends on nothing.
`default_nettype none

package rgb2hsv_pkg;

   // Component and result widths
   localparam int COMP_BITS      = 8;
   localparam int HUE_BITS       = 15;
   localparam int SAT_BITS       = 8;
   localparam int REQ_DATA_BITS  = 24;
   localparam int RSP_DATA_BITS  = 32;

   // Quotient widths of the two long divisions
   localparam int SAT_QUO_BITS   = 8;
   localparam int HUE_QUO_BITS   = 12;

   // Pipeline layout: capture, min/max, prep, then one stage per hue quotient bit
   localparam int DIV_FIRST      = 3;
   localparam int PIPE_STAGES    = DIV_FIRST + HUE_QUO_BITS;

   // Fixed-point scale factors (hue in degrees with 6 fraction bits)
   localparam logic [15:0] SAT_SCALE    = 16'd255;
   localparam logic [19:0] HUE_SCALE    = 20'd3840;
   localparam logic [15:0] SPAN_GREEN   = 16'd7680;
   localparam logic [15:0] SPAN_BLUE    = 16'd15360;
   localparam logic [15:0] SPAN_CIRCLE  = 16'd23040;

   typedef enum logic [1:0] {
      SECTOR_RED   = 2'd0,
      SECTOR_GREEN = 2'd1,
      SECTOR_BLUE  = 2'd2
   } sector_type;

   // Work carried down the pipeline; each stage fills in what it owns
   typedef struct packed {
      logic [COMP_BITS-1:0]    red;
      logic [COMP_BITS-1:0]    green;
      logic [COMP_BITS-1:0]    blue;
      logic [COMP_BITS-1:0]    mx;
      logic [COMP_BITS-1:0]    mn;
      sector_type              sector;
      logic                    neg;
      logic [COMP_BITS-1:0]    delta;
      logic [COMP_BITS-1:0]    srem;
      logic [SAT_QUO_BITS-1:0] snum;
      logic [SAT_QUO_BITS-1:0] squo;
      logic [COMP_BITS-1:0]    hrem;
      logic [HUE_QUO_BITS-1:0] hnum;
      logic [HUE_QUO_BITS-1:0] hquo;
   } work_type;

endpackage

`default_nettype wire

FILE: src/rgb_to_hsv_converter.sv
// RGB to HSV pixel converter, a fully pipelined stream block.
// Depends on src/rgb2hsv_pkg.sv for types and constants.
`default_nettype none

// Converts one 8-bit RGB pixel per clock into hue (degrees times 64), saturation
// (255 = 1.0) and brightness (the largest component). One pixel enters every
// cycle as long as results are taken. An accepted input beat reaches its
// result beat through input capture, min/max and sector select,
// numerator prep, twelve restoring-division stages that each resolve one bit
// of the hue quotient (the saturation quotient rides along in the first
// eight), and the output register. The division stages set the depth. Each
// stage holds its own valid bit and loads whenever it is empty or its
// successor loads, so a stalled result only backs up stages that are full and
// bubbles are squeezed out. Black and grey pixels give hue 0; ties for the
// maximum favor red, then green, then blue. Reset clears the valid bits only.
module rgb_to_hsv_converter (
   input  wire logic        clock,
   input  wire logic        reset,
   // req_tdata: red [7:0], green [15:8], blue [23:16]
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [rgb2hsv_pkg::REQ_DATA_BITS-1:0] req_tdata,
   // rsp_tdata: hue [14:0], saturation [22:15], brightness [30:23], zero [31]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [rgb2hsv_pkg::RSP_DATA_BITS-1:0] rsp_tdata
);

   localparam int NST = rgb2hsv_pkg::PIPE_STAGES;
   localparam int CB  = rgb2hsv_pkg::COMP_BITS;
   localparam int HQ  = rgb2hsv_pkg::HUE_QUO_BITS;
   localparam int SQ  = rgb2hsv_pkg::SAT_QUO_BITS;

   rgb2hsv_pkg::work_type stage_ff [NST];
   rgb2hsv_pkg::work_type stage_in [NST];
   logic [NST-1:0]        valid_ff;
   logic [NST-1:0]        valid_src;
   logic [NST:0]          take;

   logic                                  rsp_tvalid_ff;
   logic [rgb2hsv_pkg::RSP_DATA_BITS-1:0] rsp_tdata_ff;
   logic [rgb2hsv_pkg::RSP_DATA_BITS-1:0] rsp_tdata_in;

   // A stage loads when it is empty or its content moves on this cycle
   always_comb begin
      take[NST] = !rsp_tvalid_ff || rsp_tready;
      for (int k = NST - 1; k >= 0; k--) begin
         take[k] = !valid_ff[k] || take[k+1];
      end
   end

   assign valid_src  = {valid_ff[NST-2:0], req_tvalid};
   assign req_tready = take[0];

   // Per-stage work
   for (genvar i = 0; i < NST; i++) begin : g_stage
      if (i == 0) begin : g_capture
         // Unpack the input beat
         always_comb begin
            stage_in[0]       = '0;
            stage_in[0].red   = req_tdata[CB-1:0];
            stage_in[0].green = req_tdata[2*CB-1:CB];
            stage_in[0].blue  = req_tdata[3*CB-1:2*CB];
         end
      end else if (i == 1) begin : g_minmax
         // Find max, min and the sector; ties go red, then green, then blue
         always_comb begin
            rgb2hsv_pkg::work_type w;
            w = stage_ff[0];
            if (w.red >= w.green && w.red >= w.blue) begin
               w.sector = rgb2hsv_pkg::SECTOR_RED;
               w.mx     = w.red;
            end else if (w.green >= w.blue) begin
               w.sector = rgb2hsv_pkg::SECTOR_GREEN;
               w.mx     = w.green;
            end else begin
               w.sector = rgb2hsv_pkg::SECTOR_BLUE;
               w.mx     = w.blue;
            end
            w.mn = w.red;
            if (w.green < w.mn) begin
               w.mn = w.green;
            end
            if (w.blue < w.mn) begin
               w.mn = w.blue;
            end
            stage_in[1] = w;
         end
      end else if (i == 2) begin : g_prep
         // Form delta, |diff| and both numerators; seed the partial remainders
         always_comb begin
            rgb2hsv_pkg::work_type w;
            logic [CB-1:0] hi;
            logic [CB-1:0] lo;
            logic [CB-1:0] dmag;
            logic [15:0]   snum_full;
            logic [19:0]   hnum_full;
            w = stage_ff[1];
            case (w.sector)
               rgb2hsv_pkg::SECTOR_RED: begin
                  hi = w.green;
                  lo = w.blue;
               end
               rgb2hsv_pkg::SECTOR_GREEN: begin
                  hi = w.blue;
                  lo = w.red;
               end
               default: begin
                  hi = w.red;
                  lo = w.green;
               end
            endcase
            w.neg     = hi < lo;
            dmag      = w.neg ? (lo - hi) : (hi - lo);
            w.delta   = w.mx - w.mn;
            snum_full = {8'd0, w.delta} * rgb2hsv_pkg::SAT_SCALE;
            hnum_full = {12'd0, dmag} * rgb2hsv_pkg::HUE_SCALE;
            // Quotients fit their widths, so the top bits start below the divisor
            w.srem    = snum_full[15:8];
            w.snum    = snum_full[7:0];
            w.squo    = '0;
            w.hrem    = hnum_full[19:12];
            w.hnum    = hnum_full[11:0];
            w.hquo    = '0;
            stage_in[2] = w;
         end
      end else begin : g_div
         localparam int J = i - rgb2hsv_pkg::DIV_FIRST;
         // One restoring step per stage; saturation only in the first steps
         always_comb begin
            rgb2hsv_pkg::work_type w;
            logic [CB:0] h_trial;
            logic        h_ge;
            logic [CB:0] s_trial;
            logic        s_ge;
            w       = stage_ff[i-1];
            h_trial = {w.hrem, w.hnum[HQ-1]};
            h_ge    = h_trial >= {1'b0, w.delta};
            if (h_ge) begin
               h_trial = h_trial - {1'b0, w.delta};
            end
            w.hrem  = h_trial[CB-1:0];
            w.hnum  = {w.hnum[HQ-2:0], 1'b0};
            w.hquo  = {w.hquo[HQ-2:0], h_ge};
            s_trial = {w.srem, w.snum[SQ-1]};
            s_ge    = s_trial >= {1'b0, w.mx};
            if (s_ge) begin
               s_trial = s_trial - {1'b0, w.mx};
            end
            if (J < SQ) begin
               w.srem = s_trial[CB-1:0];
               w.snum = {w.snum[SQ-2:0], 1'b0};
               w.squo = {w.squo[SQ-2:0], s_ge};
            end
            stage_in[i] = w;
         end
      end
   end

   // Valid bits: cleared by reset, advance with their stage
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < NST; k++) begin
            if (take[k]) begin
               valid_ff[k] <= valid_src[k];
            end
         end
      end
   end

   // Payload: load when the stage takes, hold otherwise
   always_ff @(posedge clock) begin
      for (int k = 0; k < NST; k++) begin
         if (take[k]) begin
            stage_ff[k] <= stage_in[k];
         end
      end
   end

   // Assemble hue from sector base and quotient; force black and grey to zero
   always_comb begin
      rgb2hsv_pkg::work_type w;
      logic [15:0] base;
      logic [15:0] part;
      logic [15:0] hue;
      logic [rgb2hsv_pkg::SAT_BITS-1:0] sat;
      w    = stage_ff[NST-1];
      part = {4'd0, w.hquo};
      case (w.sector)
         rgb2hsv_pkg::SECTOR_RED:   base = '0;
         rgb2hsv_pkg::SECTOR_GREEN: base = rgb2hsv_pkg::SPAN_GREEN;
         default:                   base = rgb2hsv_pkg::SPAN_BLUE;
      endcase
      if (w.delta == '0) begin
         hue = '0;
      end else if (!w.neg) begin
         hue = base + part;
      end else if (base >= part) begin
         hue = base - part;
      end else begin
         // Wrap a negative red-sector hue around the circle
         hue = base + rgb2hsv_pkg::SPAN_CIRCLE - part;
      end
      sat = (w.mx == '0) ? '0 : w.squo;
      rsp_tdata_in = {1'b0, w.mx, sat, hue[rgb2hsv_pkg::HUE_BITS-1:0]};
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (take[NST]) begin
         rsp_tvalid_ff <= valid_ff[NST-1];
      end
   end

   always_ff @(posedge clock) begin
      if (take[NST]) begin
         rsp_tdata_ff <= rsp_tdata_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // Grey or black results carry hue zero
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[22:15] == 8'd0) |-> rsp_tdata[14:0] == 15'd0)
      else $error("nonzero hue on a zero-saturation beat");

   // Hue stays below the full circle
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[14:0] < 15'd23040)
      else $error("hue out of range");

   // Input back-pressure only when every stage holds a pixel
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (&valid_ff))
      else $error("input stalled with a free stage");

   // A blocked last stage keeps its pixel
   assert property (@(posedge clock) disable iff (reset)
      (valid_ff[NST-1] && !take[NST]) |=> $stable(stage_ff[NST-1]) && valid_ff[NST-1])
      else $error("last stage changed while blocked");

endmodule

`default_nettype wire
